@@ rtl/core/euler_rotation_matrix_gen_defines.svh @@
// Assertion macros for the Euler rotation matrix generator.
`ifndef EULER_ROTATION_MATRIX_GEN_DEFINES_SVH
`define EULER_ROTATION_MATRIX_GEN_DEFINES_SVH
// Concurrent assertion with asynchronous reset disable.
`define ERM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Implication checked on the next clock edge.
`define ERM_ASSERT_NEXT(lbl, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`endif

@@ rtl/core/erm_pkg.sv @@
// Package with the CORDIC arctangent table and fixed-point constants.
package erm_pkg;
    localparam int Q30_HALF_C = 536870912;
    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
    localparam logic [31:0] ATAN_TABLE [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };
    typedef logic signed [33:0] cq_t;
    typedef logic signed [32:0] ph_t;
    typedef struct packed {
        cq_t x;
        cq_t y;
        ph_t z;
        logic flip;
    } cordic_t;
    // Q30 product with round-half-up and floor shift.
    function automatic cq_t qmul(input cq_t a, input cq_t b);
        logic signed [67:0] p;
        p = 68'(a) * 68'(b) + 68'(Q30_HALF_C);
        return cq_t'(p >>> 30);
    endfunction
endpackage

@@ rtl/core/euler_rotation_matrix_gen.sv @@
// Euler angle to rotation matrix generator, fully pipelined CORDIC and products.
//
// Usage: drive angle_x, angle_y, angle_z and pulse start. busy is always low,
// so a new item is taken on every cycle that start is high.
// Each item is first registered with its phase folded, then runs through
// TRIG_STAGES CORDIC stages (one register per stage, three angles in parallel
// lanes), then four more register stages: sign unfold, first products, second
// products with sums, and rounding with clamp. Throughput is one item per
// cycle, set by the CORDIC stage chain.
// done marks the single cycle in which m00..m22 hold the result; the
// receiver must take it then, since it cannot hold results off.
// Reset clears all valid bits; items in flight are dropped.
`include "euler_rotation_matrix_gen_defines.svh"
module euler_rotation_matrix_gen
    import erm_pkg::*;
#(
    parameter int ANGLE_WIDTH = 16,
    parameter int FRAC_BITS   = 14,
    parameter int TRIG_STAGES = 16
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] angle_x,
    input  logic signed [15:0] angle_y,
    input  logic signed [15:0] angle_z,
    output logic               done,
    output logic signed [15:0] m00,
    output logic signed [15:0] m01,
    output logic signed [15:0] m02,
    output logic signed [15:0] m10,
    output logic signed [15:0] m11,
    output logic signed [15:0] m12,
    output logic signed [15:0] m20,
    output logic signed [15:0] m21,
    output logic signed [15:0] m22
);
    localparam int SHIFT = 30 - FRAC_BITS;
    localparam int DROP  = 32 - ANGLE_WIDTH;
    localparam logic [31:0] PH_MASK = 32'hFFFF_FFFF << DROP;
    localparam cq_t LIM = cq_t'(64'sd1 <<< FRAC_BITS);
    localparam cq_t RND = (SHIFT > 0) ? cq_t'(64'sd1 <<< (SHIFT - 1)) : cq_t'(0);

    assign busy = 1'b0;

    // Phase fold into the right half-plane.
    function automatic cordic_t seed(input logic [15:0] a);
        cordic_t   c;
        logic [31:0] ph;
        ph = {a, 16'h0000} & PH_MASK;
        c.flip = (ph[31:30] == 2'b01) || (ph[31:30] == 2'b10);
        if (c.flip)
            ph = ph + 32'h8000_0000;
        c.x = CORDIC_X0;
        c.y = '0;
        c.z = ph_t'(signed'(ph));
        return c;
    endfunction

    cordic_t cx_reg [TRIG_STAGES+1];
    cordic_t cy_reg [TRIG_STAGES+1];
    cordic_t cz_reg [TRIG_STAGES+1];
    logic    cv_reg [TRIG_STAGES+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cv_reg[0] <= 1'b0;
        else
            cv_reg[0] <= start;
    end

    always_ff @(posedge clk)
    begin
        cx_reg[0] <= seed(angle_x);
        cy_reg[0] <= seed(angle_y);
        cz_reg[0] <= seed(angle_z);
    end

    function automatic cordic_t rot(input cordic_t c, input int i);
        cordic_t r;
        cq_t dx;
        cq_t dy;
        ph_t at;
        r  = c;
        dx = c.y >>> i;
        dy = c.x >>> i;
        at = ph_t'({1'b0, ATAN_TABLE[i]});
        if (!c.z[32])
        begin
            r.x = c.x - dx;
            r.y = c.y + dy;
            r.z = c.z - at;
        end
        else
        begin
            r.x = c.x + dx;
            r.y = c.y - dy;
            r.z = c.z + at;
        end
        return r;
    endfunction

    for (genvar g = 0; g < TRIG_STAGES; g++)
    begin : g_cordic
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                cv_reg[g+1] <= 1'b0;
            else
                cv_reg[g+1] <= cv_reg[g];
        end
        always_ff @(posedge clk)
        begin
            cx_reg[g+1] <= rot(cx_reg[g], g);
            cy_reg[g+1] <= rot(cy_reg[g], g);
            cz_reg[g+1] <= rot(cz_reg[g], g);
        end
    end

    cordic_t fx, fy, fz;
    assign fx = cx_reg[TRIG_STAGES];
    assign fy = cy_reg[TRIG_STAGES];
    assign fz = cz_reg[TRIG_STAGES];

    // Stage A: unfold signs.
    cq_t sx_reg, cxv_reg, sy_reg, cyv_reg, sz_reg, czv_reg;
    logic va_reg, vb_reg, vc_reg, vd_reg;
    always_ff @(posedge clk)
    begin
        sx_reg  <= fx.flip ? -fx.y : fx.y;
        cxv_reg <= fx.flip ? -fx.x : fx.x;
        sy_reg  <= fy.flip ? -fy.y : fy.y;
        cyv_reg <= fy.flip ? -fy.x : fy.x;
        sz_reg  <= fz.flip ? -fz.y : fz.y;
        czv_reg <= fz.flip ? -fz.x : fz.x;
    end

    // Stage B: first products.
    cq_t czsy_reg, szsy_reg, czcy_reg, szcy_reg, cysx_reg, cycx_reg, nsy_reg;
    cq_t szcx_reg, szsx_reg, czcx_reg, czsx_reg, sxb_reg, cxb_reg;
    always_ff @(posedge clk)
    begin
        czsy_reg <= qmul(czv_reg, sy_reg);
        szsy_reg <= qmul(sz_reg, sy_reg);
        czcy_reg <= qmul(czv_reg, cyv_reg);
        szcy_reg <= -qmul(sz_reg, cyv_reg);
        cysx_reg <= qmul(cyv_reg, sx_reg);
        cycx_reg <= qmul(cyv_reg, cxv_reg);
        nsy_reg  <= -sy_reg;
        szcx_reg <= qmul(sz_reg, cxv_reg);
        szsx_reg <= qmul(sz_reg, sx_reg);
        czcx_reg <= qmul(czv_reg, cxv_reg);
        czsx_reg <= qmul(czv_reg, sx_reg);
        sxb_reg  <= sx_reg;
        cxb_reg  <= cxv_reg;
    end

    // Stage C: second products and sums.
    cq_t e_reg [9];
    always_ff @(posedge clk)
    begin
        e_reg[0] <= czcy_reg;
        e_reg[1] <= szcx_reg + qmul(czsy_reg, sxb_reg);
        e_reg[2] <= qmul(czsy_reg, cxb_reg) - szsx_reg;
        e_reg[3] <= szcy_reg;
        e_reg[4] <= czcx_reg - qmul(szsy_reg, sxb_reg);
        e_reg[5] <= -czsx_reg - qmul(szsy_reg, cxb_reg);
        e_reg[6] <= nsy_reg;
        e_reg[7] <= cysx_reg;
        e_reg[8] <= cycx_reg;
    end

    function automatic logic [15:0] to_out(input cq_t v);
        cq_t r;
        r = (v + RND) >>> SHIFT;
        if (r > LIM)
            r = LIM;
        if (r < -LIM)
            r = -LIM;
        return r[15:0];
    endfunction

    // Stage D: round, clamp and register outputs.
    logic [15:0] o_reg [9];
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 9; k++)
            o_reg[k] <= to_out(e_reg[k]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end
        else
        begin
            va_reg <= cv_reg[TRIG_STAGES];
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
        end
    end

    assign done = vd_reg;
    assign m00 = o_reg[0];
    assign m01 = o_reg[1];
    assign m02 = o_reg[2];
    assign m10 = o_reg[3];
    assign m11 = o_reg[4];
    assign m12 = o_reg[5];
    assign m20 = o_reg[6];
    assign m21 = o_reg[7];
    assign m22 = o_reg[8];

    // With a wide fraction the output is truncated, so the range holds only up to 14 bits.
    logic diag_ok;
    assign diag_ok = (FRAC_BITS > 14) || ((m22 <= 16'sd16384) && (m22 >= -16'sd16384));

    `ERM_ASSERT(a_busy_low, !busy, "busy must stay low")
    `ERM_ASSERT_NEXT(a_valid_chain, vc_reg, done, "valid lost in output stage")
    `ERM_ASSERT(a_diag_range, !done || diag_ok, "m22 out of range")
endmodule

@@ tb/sv/euler_rotation_matrix_gen_tb.sv @@
// Testbench for the Euler angle to rotation matrix generator.
module euler_rotation_matrix_gen_tb;
    import erm_pkg::*;

    localparam int ANGLE_W   = 16;
    localparam int FRAC_W    = 14;
    localparam int STAGES    = 16;
    localparam int LATENCY   = STAGES + 5;
    localparam int MAX_CYCLE = 400000;

    typedef struct {
        logic [15:0] m [9];
    } matrix_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [15:0] angle_x = '0;
    logic signed [15:0] angle_y = '0;
    logic signed [15:0] angle_z = '0;
    logic done;
    logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

    matrix_t expected_matrices[$];
    int mismatch_count = 0;
    int cycle_count = 0;
    bit allow_idle = 1'b1;

    always #1 clk = ~clk;

    euler_rotation_matrix_gen u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .angle_x(angle_x), .angle_y(angle_y), .angle_z(angle_z), .done(done),
        .m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11), .m12(m12),
        .m20(m20), .m21(m21), .m22(m22)
    );

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint q30_mul(longint a, longint b);
        return floor_shr(a * b + 64'sd536870912, 30);
    endfunction

    // Rotation-mode CORDIC over the folded phase; results are Q30.
    function automatic void trig_of(input logic [15:0] ang, output longint sn,
                                    output longint cs);
        logic [31:0] phase;
        bit flip;
        longint x, y, z, dx, dy, step;
        phase = {ang, 16'h0000};
        if (ANGLE_W < 32)
            phase &= ~((32'h1 << (32 - ANGLE_W)) - 32'h1);
        flip = (phase >= 32'h4000_0000) && (phase < 32'hC000_0000);
        if (flip)
            phase += 32'h8000_0000;
        z = longint'($signed(phase));
        x = 64'sd652032874;
        y = 0;
        for (int i = 0; i < STAGES && i < 32; i++)
        begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            step = longint'(ATAN_TABLE[i]);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= step;
            end
            else
            begin
                x += dx; y -= dy; z += step;
            end
        end
        if (flip)
        begin
            x = -x; y = -y;
        end
        cs = x;
        sn = y;
    endfunction

    function automatic logic [15:0] to_q14(longint v);
        longint r, lim;
        int s;
        s = 30 - FRAC_W;
        lim = longint'(1) << FRAC_W;
        r = v;
        if (s > 0)
            r = floor_shr(v + (longint'(1) << (s - 1)), s);
        if (r > lim)
            r = lim;
        if (r < -lim)
            r = -lim;
        return r[15:0];
    endfunction

    function automatic matrix_t rotation_of(logic [15:0] ax, logic [15:0] ay, logic [15:0] az);
        matrix_t mt;
        longint sx, cx, sy, cy, sz, cz, czsy, szsy;
        trig_of(ax, sx, cx);
        trig_of(ay, sy, cy);
        trig_of(az, sz, cz);
        czsy = q30_mul(cz, sy);
        szsy = q30_mul(sz, sy);
        mt.m[0] = to_q14(q30_mul(cz, cy));
        mt.m[1] = to_q14(q30_mul(sz, cx) + q30_mul(czsy, sx));
        mt.m[2] = to_q14(-q30_mul(sz, sx) + q30_mul(czsy, cx));
        mt.m[3] = to_q14(-q30_mul(sz, cy));
        mt.m[4] = to_q14(q30_mul(cz, cx) - q30_mul(szsy, sx));
        mt.m[5] = to_q14(-q30_mul(cz, sx) - q30_mul(szsy, cx));
        mt.m[6] = to_q14(-sy);
        mt.m[7] = to_q14(q30_mul(cy, sx));
        mt.m[8] = to_q14(q30_mul(cy, cx));
        return mt;
    endfunction

    // Sends one item, with an optional random gap before it.
    task automatic send_angles(input logic [15:0] ax, input logic [15:0] ay,
                               input logic [15:0] az);
        int gap;
        if (allow_idle && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 7);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        angle_x <= ax;
        angle_y <= ay;
        angle_z <= az;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_matrices.push_back(rotation_of(ax, ay, az));
    endtask

    task automatic go_idle();
        start <= 1'b0;
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        matrix_t exp_m;
        logic [15:0] got [9];
        cycle_count <= cycle_count + 1;
        if (rst_n && done)
        begin
            got = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
            if (expected_matrices.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected matrix at cycle %0d", cycle_count);
            end
            else
            begin
                exp_m = expected_matrices.pop_front();
                for (int k = 0; k < 9; k++)
                    if (got[k] !== exp_m.m[k])
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("Entry m%0d%0d: expected %h, got %h",
                                     k / 3, k % 3, exp_m.m[k], got[k]);
                    end
            end
        end
        if (cycle_count >= MAX_CYCLE)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Extremes, quarter turns and the points next to the quadrant fold.
    task automatic test_directed();
        logic [15:0] pts [12] = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h4000,
            16'hC000, 16'h3FFF, 16'h4001, 16'hBFFF, 16'hC001, 16'h2000, 16'h0001};
        for (int i = 0; i < 12; i++)
            send_angles(pts[i], pts[(i + 3) % 12], pts[(i + 7) % 12]);
        send_angles(16'h0000, 16'h0000, 16'h0000);
        send_angles(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_angles(16'h8000, 16'h8000, 16'h8000);
        send_angles(16'h5555, 16'hAAAA, 16'h5555);
    endtask

    // The sender holds off until the pipeline has drained completely.
    task automatic test_drain_pause();
        go_idle();
        while (expected_matrices.size() != 0)
            @(posedge clk);
        send_angles(16'h1234, 16'hEDCB, 16'h4000);
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
            send_angles(16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_drain_pause();
        test_random(1500);
        // Back-to-back items at full rate for the last part.
        allow_idle = 1'b0;
        test_random(380);
        go_idle();
        while (expected_matrices.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
        if (mismatch_count == 0 && expected_matrices.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/erm_pkg.sv
rtl/core/euler_rotation_matrix_gen.sv
tb/sv/euler_rotation_matrix_gen_tb.sv
